/* hw/rtl/sacl_pkg.sv */
// Shared types and constants for the set-associative cache array.
// Field widths, request codes and the metadata write-enable group.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package sacl_pkg;

  localparam int REQ_W     = 3;
  localparam int SET_IN_W  = 6;
  localparam int TAG_W     = 21;
  localparam int WAY_IN_W  = 2;
  localparam int WORD_IN_W = 5;
  localparam int DATA_W    = 8;
  localparam int STATUS_W  = 3;
  localparam int STAMP_W   = 32;

  localparam int SET_IN_N  = 2 ** SET_IN_W;
  localparam int WAY_IN_N  = 2 ** WAY_IN_W;
  localparam int WORD_IN_N = 2 ** WORD_IN_W;

  localparam logic [STATUS_W-1:0]      NO_COPIES_CODE = 3'd0;
  localparam logic signed [DATA_W-1:0] FILL_VALUE     = 8'sd4;

  typedef enum logic [REQ_W-1:0] {
    REQ_LOOKUP = 3'd0,
    REQ_READ   = 3'd1,
    REQ_WRITE  = 3'd2,
    REQ_FILL   = 3'd3,
    REQ_STATUS = 3'd4,
    REQ_VICTIM = 3'd5
  } req_t;

  typedef struct packed {
    logic tag;
    logic status;
    logic stamp;
  } meta_we_t;

endpackage

`default_nettype wire

/* hw/rtl/sacl_if.sv */
// Request and response channel interfaces of the cache array.
// Depends on sacl_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface sacl_req_if import sacl_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic [REQ_W-1:0]           req_type;
  logic [SET_IN_W-1:0]        set_index;
  logic [TAG_W-1:0]           tag_in;
  logic [WAY_IN_W-1:0]        way_in;
  logic [WORD_IN_W-1:0]       word_index;
  logic signed [DATA_W-1:0]   write_data;
  logic [STATUS_W-1:0]        new_status;

  modport source (
    output valid, req_type, set_index, tag_in, way_in, word_index, write_data,
           new_status,
    input  ready
  );
  modport sink (
    input  valid, req_type, set_index, tag_in, way_in, word_index, write_data,
           new_status,
    output ready
  );
endinterface

interface sacl_rsp_if import sacl_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic                       hit;
  logic [WAY_IN_W-1:0]        hit_way;
  logic signed [DATA_W-1:0]   read_data;
  logic [STATUS_W-1:0]        status_out;
  logic [WAY_IN_W-1:0]        victim_way;

  modport source (
    output valid, hit, hit_way, read_data, status_out, victim_way,
    input  ready
  );
  modport sink (
    input  valid, hit, hit_way, read_data, status_out, victim_way,
    output ready
  );
endinterface

`default_nettype wire

/* hw/rtl/set_assoc_cache_array_lru.sv */
// Top level of the set-associative cache array with oldest-stamp victim choice.
// Channels: in_req (request words) and out_rsp (one response word per request),
// both valid/ready; a word moves on a clock edge with valid and ready high.
// Each request is worked on alone by the sequencer; in_req.ready is high only
// while it is idle. Every request passes the read and evaluate states before the
// response register; fill adds a sweep over WORDS_PER_LINE words, victim scans
// every way, and lookup scans the ways until the first hit. The next request
// can be taken in the cycle after the response is registered. The scans go one
// way at a time through the single metadata read port, and a fill writes one
// word per cycle through the one data write port.
// After reset a clearing pass over all SETS * WAYS slots sets every status to the
// no-copies code and every stamp to zero; no request is taken meanwhile.
// The response sits in an output register; a stalled receiver holds it there
// while the next request is accepted and worked on, and that request waits
// for the receiver to take the held response before it is answered.
// Depends on sacl_pkg, sacl_if, sacl_meta_store, sacl_data_store, sacl_ctrl.
`timescale 1ns / 1ps
`default_nettype none

module set_assoc_cache_array_lru import sacl_pkg::*; #(
  parameter int WAYS           = 4,
  parameter int SETS           = 64,
  parameter int WORDS_PER_LINE = 32
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  sacl_req_if.sink    in_req,
  sacl_rsp_if.source  out_rsp
);

  localparam int SLOTS   = SETS * WAYS;
  localparam int DEPTH   = SLOTS * WORDS_PER_LINE;
  localparam int SLOT_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int DADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [SLOT_W-1:0]         meta_rd_addr;
  logic [TAG_W-1:0]          tag_q;
  logic [STATUS_W-1:0]       status_q;
  logic [STAMP_W-1:0]        stamp_q;
  logic [SLOT_W-1:0]         meta_wr_addr;
  meta_we_t                  meta_we;
  logic [TAG_W-1:0]          tag_wd;
  logic [STATUS_W-1:0]       status_wd;
  logic [STAMP_W-1:0]        stamp_wd;
  logic [DADDR_W-1:0]        data_rd_addr;
  logic signed [DATA_W-1:0]  data_q;
  logic                      data_we;
  logic [DADDR_W-1:0]        data_wr_addr;
  logic signed [DATA_W-1:0]  data_wd;

  sacl_ctrl #(
    .WAYS           (WAYS),
    .SETS           (SETS),
    .WORDS_PER_LINE (WORDS_PER_LINE)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_req       (in_req),
    .out_rsp      (out_rsp),
    .meta_rd_addr (meta_rd_addr),
    .tag_q        (tag_q),
    .status_q     (status_q),
    .stamp_q      (stamp_q),
    .meta_wr_addr (meta_wr_addr),
    .meta_we      (meta_we),
    .tag_wd       (tag_wd),
    .status_wd    (status_wd),
    .stamp_wd     (stamp_wd),
    .data_rd_addr (data_rd_addr),
    .data_q       (data_q),
    .data_we      (data_we),
    .data_wr_addr (data_wr_addr),
    .data_wd      (data_wd)
  );

  sacl_meta_store #(
    .SLOTS (SLOTS)
  ) u_meta_store (
    .clk       (clk),
    .rd_addr   (meta_rd_addr),
    .tag_q     (tag_q),
    .status_q  (status_q),
    .stamp_q   (stamp_q),
    .wr_addr   (meta_wr_addr),
    .we        (meta_we),
    .tag_wd    (tag_wd),
    .status_wd (status_wd),
    .stamp_wd  (stamp_wd)
  );

  sacl_data_store #(
    .DEPTH (DEPTH)
  ) u_data_store (
    .clk     (clk),
    .rd_addr (data_rd_addr),
    .rd_data (data_q),
    .we      (data_we),
    .wr_addr (data_wr_addr),
    .wr_data (data_wd)
  );

endmodule

`default_nettype wire

/* hw/rtl/sacl_meta_store.sv */
// Per-slot metadata memories: tag, coherence status and last-use stamp.
// One shared read address with registered data, one write address.
// Depends on sacl_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sacl_meta_store import sacl_pkg::*; #(
  parameter int SLOTS = 256
) (
  input  wire logic                                    clk,
  input  wire logic [(SLOTS > 1 ? $clog2(SLOTS) : 1)-1:0] rd_addr,
  output logic [TAG_W-1:0]                             tag_q,
  output logic [STATUS_W-1:0]                          status_q,
  output logic [STAMP_W-1:0]                           stamp_q,
  input  wire logic [(SLOTS > 1 ? $clog2(SLOTS) : 1)-1:0] wr_addr,
  input  wire meta_we_t                                we,
  input  wire logic [TAG_W-1:0]                        tag_wd,
  input  wire logic [STATUS_W-1:0]                     status_wd,
  input  wire logic [STAMP_W-1:0]                      stamp_wd
);

  logic [TAG_W-1:0]    tag_mem    [SLOTS];
  logic [STATUS_W-1:0] status_mem [SLOTS];
  logic [STAMP_W-1:0]  stamp_mem  [SLOTS];

  always_ff @(posedge clk) begin
    if (we.tag) begin
      tag_mem[wr_addr] <= tag_wd;
    end
    tag_q <= tag_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (we.status) begin
      status_mem[wr_addr] <= status_wd;
    end
    status_q <= status_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (we.stamp) begin
      stamp_mem[wr_addr] <= stamp_wd;
    end
    stamp_q <= stamp_mem[rd_addr];
  end

endmodule

`default_nettype wire

/* hw/rtl/sacl_data_store.sv */
// Byte data memory of the cache array, one word per entry.
// One write port and one read port with registered data.
// Depends on sacl_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sacl_data_store import sacl_pkg::*; #(
  parameter int DEPTH = 8192
) (
  input  wire logic                                        clk,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0]  rd_addr,
  output logic signed [DATA_W-1:0]                         rd_data,
  input  wire logic                                        we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0]  wr_addr,
  input  wire logic signed [DATA_W-1:0]                    wr_data
);

  logic signed [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

/* hw/rtl/sacl_ctrl.sv */
// Request sequencer of the cache array: clearing pass, per-way scan with a
// shared tag and stamp comparator, line fill sweep and the response register.
// Depends on sacl_pkg and the sacl_req_if and sacl_rsp_if interfaces.
`timescale 1ns / 1ps
`default_nettype none

module sacl_ctrl import sacl_pkg::*; #(
  parameter int WAYS           = 4,
  parameter int SETS           = 64,
  parameter int WORDS_PER_LINE = 32,
  localparam int SLOTS   = SETS * WAYS,
  localparam int DEPTH   = SLOTS * WORDS_PER_LINE,
  localparam int SLOT_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1,
  localparam int DADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  sacl_req_if.sink                        in_req,
  sacl_rsp_if.source                      out_rsp,
  output logic [SLOT_W-1:0]               meta_rd_addr,
  input  wire logic [TAG_W-1:0]           tag_q,
  input  wire logic [STATUS_W-1:0]        status_q,
  input  wire logic [STAMP_W-1:0]         stamp_q,
  output logic [SLOT_W-1:0]               meta_wr_addr,
  output meta_we_t                        meta_we,
  output logic [TAG_W-1:0]                tag_wd,
  output logic [STATUS_W-1:0]             status_wd,
  output logic [STAMP_W-1:0]              stamp_wd,
  output logic [DADDR_W-1:0]              data_rd_addr,
  input  wire logic signed [DATA_W-1:0]   data_q,
  output logic                            data_we,
  output logic [DADDR_W-1:0]              data_wr_addr,
  output logic signed [DATA_W-1:0]        data_wd
);

  localparam int SET_W  = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int WAY_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int WORD_W = (WORDS_PER_LINE > 1) ? $clog2(WORDS_PER_LINE) : 1;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_EVAL,
    S_FILL,
    S_DONE
  } state_t;

  state_t                    state_r;
  logic [REQ_W-1:0]          req_r;
  logic [SLOT_W-1:0]         base_r;
  logic [WAY_W-1:0]          way_r;
  logic [WORD_W-1:0]         word_r;
  logic [TAG_W-1:0]          tag_r;
  logic signed [DATA_W-1:0]  wdata_r;
  logic [STATUS_W-1:0]       nstat_r;
  logic [STAMP_W-1:0]        use_cnt_r;
  logic [SLOT_W-1:0]         clr_cnt_r;
  logic [WORD_W-1:0]         fill_cnt_r;
  logic [WAY_W-1:0]          best_r;
  logic [STAMP_W-1:0]        best_stamp_r;
  logic [STATUS_W-1:0]       best_stat_r;
  logic                      res_hit_r;
  logic [WAY_W-1:0]          res_hit_way_r;
  logic signed [DATA_W-1:0]  res_rdata_r;
  logic [STATUS_W-1:0]       res_stat_r;
  logic [WAY_W-1:0]          res_victim_r;
  logic                      out_valid_r;
  logic                      out_hit_r;
  logic [WAY_IN_W-1:0]       out_hit_way_r;
  logic signed [DATA_W-1:0]  out_rdata_r;
  logic [STATUS_W-1:0]       out_stat_r;
  logic [WAY_IN_W-1:0]       out_victim_r;

  logic [SET_W-1:0]   set_map  [SET_IN_N];
  logic [WAY_W-1:0]   way_map  [WAY_IN_N];
  logic [WORD_W-1:0]  word_map [WORD_IN_N];

  logic [SLOT_W-1:0]  slot;
  logic [DADDR_W-1:0] line_base;
  logic [STAMP_W-1:0] stamp_inc;
  logic               tag_match;
  logic               take;
  logic               way_last;

  // Out-of-range indexes wrap; the remainders are fixed at elaboration.
  for (genvar g = 0; g < SET_IN_N; g++) begin : g_set_map
    assign set_map[g] = SET_W'(g % SETS);
  end
  for (genvar g = 0; g < WAY_IN_N; g++) begin : g_way_map
    assign way_map[g] = WAY_W'(g % WAYS);
  end
  for (genvar g = 0; g < WORD_IN_N; g++) begin : g_word_map
    assign word_map[g] = WORD_W'(g % WORDS_PER_LINE);
  end

  assign slot      = base_r + SLOT_W'(way_r);
  assign line_base = DADDR_W'(slot * WORDS_PER_LINE);
  assign stamp_inc = use_cnt_r + 1'b1;
  assign tag_match = (status_q != NO_COPIES_CODE) && (tag_q == tag_r);
  assign take      = (way_r == '0) || (stamp_q < best_stamp_r);
  assign way_last  = (way_r == WAY_W'(WAYS - 1));

  assign meta_rd_addr = slot;
  assign data_rd_addr = line_base + DADDR_W'(word_r);
  assign data_wr_addr = line_base + DADDR_W'((state_r == S_FILL) ? fill_cnt_r : word_r);
  assign data_we      = (state_r == S_FILL) || (state_r == S_EVAL && req_r == REQ_WRITE);
  assign data_wd      = (state_r == S_FILL) ? FILL_VALUE : wdata_r;

  always_comb begin
    meta_we      = '0;
    meta_wr_addr = slot;
    tag_wd       = tag_r;
    status_wd    = nstat_r;
    stamp_wd     = stamp_inc;
    if (state_r == S_CLEAR) begin
      meta_wr_addr   = clr_cnt_r;
      meta_we.status = 1'b1;
      meta_we.stamp  = 1'b1;
      status_wd      = NO_COPIES_CODE;
      stamp_wd       = '0;
    end else if (state_r == S_EVAL) begin
      case (req_r)
        REQ_READ: begin
          meta_we.stamp = 1'b1;
        end
        REQ_WRITE, REQ_FILL: begin
          meta_we = '1;
        end
        REQ_STATUS: begin
          meta_we.status = 1'b1;
        end
        default: begin
          meta_we = '0;
        end
      endcase
    end
  end

  assign in_req.ready       = (state_r == S_IDLE);
  assign out_rsp.valid      = out_valid_r;
  assign out_rsp.hit        = out_hit_r;
  assign out_rsp.hit_way    = out_hit_way_r;
  assign out_rsp.read_data  = out_rdata_r;
  assign out_rsp.status_out = out_stat_r;
  assign out_rsp.victim_way = out_victim_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      use_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_rsp.ready && (state_r != S_DONE)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_CLEAR: begin
          clr_cnt_r <= clr_cnt_r + 1'b1;
          if (clr_cnt_r == SLOT_W'(SLOTS - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_req.valid) begin
            req_r   <= in_req.req_type;
            base_r  <= SLOT_W'(set_map[in_req.set_index] * WAYS);
            word_r  <= word_map[in_req.word_index];
            tag_r   <= in_req.tag_in;
            wdata_r <= in_req.write_data;
            nstat_r <= in_req.new_status;
            if (in_req.req_type inside {REQ_LOOKUP, REQ_VICTIM}) begin
              way_r <= '0;
            end else begin
              way_r <= way_map[in_req.way_in];
            end
            res_hit_r     <= 1'b0;
            res_hit_way_r <= '0;
            res_rdata_r   <= '0;
            res_stat_r    <= '0;
            res_victim_r  <= '0;
            state_r       <= S_READ;
          end
        end
        S_READ: begin
          state_r <= S_EVAL;
        end
        S_EVAL: begin
          case (req_r)
            REQ_LOOKUP: begin
              if (tag_match) begin
                res_hit_r     <= 1'b1;
                res_hit_way_r <= way_r;
                res_stat_r    <= status_q;
                state_r       <= S_DONE;
              end else if (way_last) begin
                res_stat_r <= NO_COPIES_CODE;
                state_r    <= S_DONE;
              end else begin
                way_r   <= way_r + 1'b1;
                state_r <= S_READ;
              end
            end
            REQ_READ: begin
              use_cnt_r   <= stamp_inc;
              res_rdata_r <= data_q;
              res_stat_r  <= status_q;
              state_r     <= S_DONE;
            end
            REQ_WRITE: begin
              use_cnt_r  <= stamp_inc;
              res_stat_r <= nstat_r;
              state_r    <= S_DONE;
            end
            REQ_FILL: begin
              use_cnt_r  <= stamp_inc;
              res_stat_r <= nstat_r;
              fill_cnt_r <= '0;
              state_r    <= S_FILL;
            end
            REQ_STATUS: begin
              res_stat_r <= nstat_r;
              state_r    <= S_DONE;
            end
            REQ_VICTIM: begin
              if (take) begin
                best_r       <= way_r;
                best_stamp_r <= stamp_q;
                best_stat_r  <= status_q;
              end
              if (way_last) begin
                res_victim_r <= take ? way_r : best_r;
                res_stat_r   <= take ? status_q : best_stat_r;
                state_r      <= S_DONE;
              end else begin
                way_r   <= way_r + 1'b1;
                state_r <= S_READ;
              end
            end
            default: begin
              state_r <= S_DONE;
            end
          endcase
        end
        S_FILL: begin
          fill_cnt_r <= fill_cnt_r + 1'b1;
          if (fill_cnt_r == WORD_W'(WORDS_PER_LINE - 1)) begin
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid_r || out_rsp.ready) begin
            out_valid_r   <= 1'b1;
            out_hit_r     <= res_hit_r;
            out_hit_way_r <= WAY_IN_W'(res_hit_way_r);
            out_rdata_r   <= res_rdata_r;
            out_stat_r    <= res_stat_r;
            out_victim_r  <= WAY_IN_W'(res_victim_r);
            state_r       <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire
